### hdl/pba_pkg.sv
// Shared types and constants for the page block allocator.
package pba_pkg;

    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 16;
    localparam int DIV_W     = 16;
    localparam int GRP_W     = 8;
    localparam int LANE_IW   = 3;
    localparam int CFG_IDX_W = 1;
    localparam int STAT_W    = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE     = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_BADSIZE  = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_code_t;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAGE_BASE = 1'b0,
        REG_PAGE_SIZE = 1'b1
    } cfg_reg_t;

    // controller -> datapath
    typedef struct packed {
        logic         load;
        logic         div_start;
        logic         do_cut;
        logic         do_release;
        logic         scan_init;
        logic         scan_step;
        logic         mul;
        logic         finish;
        status_code_t code;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_free;
        logic bsize_zero;
        logic cut;
        logic size_match;
        logic has_free;
        logic in_range;
        logic div_done;
        logic q_bad;
        logic rem_zero;
        logic idx_busy;
        logic found;
    } dp_stat_t;

endpackage

### hdl/page_block_allocator_core.sv
// Top level of the page block allocator: controller plus datapath.
//
// Manages one page cut into equal blocks. A request is taken on a clock edge
// where start is high and busy is low (kind 0 allocates a block of block_size
// bytes, kind 1 frees the block at address). busy rises the cycle after and
// stays high until the result is out.
// Each item gives exactly one result: done is high for one cycle and the
// result ports carry status, the granted address and the page state after
// the item. The receiver cannot stall; results are held until the next one.
// Early rejects go from the check straight to the result. An allocate on an
// already cut page scans the block map group by group, 8 blocks per cycle,
// until a group with a free block is found. A free that reaches the divider,
// a cut refused for its block count and a cut go through the serial divider,
// which splits the page or locates the block; a cut then also scans the map.
// The next item can start the cycle done is high.
// Configuration: cfg_index 0 is page_base, 1 is page_size; cfg_ready is
// always high, writes are expected only while busy is low.
// Reset: page free, all blocks free, page_base 0, page_size 4096.
module page_block_allocator_core #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          kind,
    input  logic [pba_pkg::SIZE_W-1:0]    block_size,
    input  logic [pba_pkg::ADDR_W-1:0]    address,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pba_pkg::ADDR_W-1:0]    cfg_data,
    output logic                          done,
    output logic [pba_pkg::STAT_W-1:0]    status,
    output logic [pba_pkg::ADDR_W-1:0]    granted_address,
    output logic                          page_is_cut,
    output logic [$clog2(MAX_BLOCKS+1)-1:0] free_count,
    output logic [$clog2(MAX_BLOCKS+1)-1:0] block_count,
    output logic [pba_pkg::SIZE_W-1:0]    current_block_size
);
    import pba_pkg::*;

    // counts go up to MAX_BLOCKS, block indexes to MAX_BLOCKS-1
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    pba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    pba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .kind               (kind),
        .block_size         (block_size),
        .address            (address),
        .cmd                (cmd),
        .stat               (stat),
        .done               (done),
        .status             (status),
        .granted_address    (granted_address),
        .page_is_cut        (page_is_cut),
        .free_count         (free_count),
        .block_count        (block_count),
        .current_block_size (current_block_size)
    );

endmodule

### hdl/pba_div.sv
// Serial restoring divider, one quotient bit per cycle.
module pba_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pba_pkg::DIV_W-1:0] dividend,
    input  logic [pba_pkg::DIV_W-1:0] divisor,
    output logic                      done,
    output logic [pba_pkg::DIV_W-1:0] quotient,
    output logic [pba_pkg::DIV_W-1:0] remainder
);
    import pba_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W-1:0] quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIV_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### hdl/pba_dp.sv
// Datapath: config registers, block map, page state, scan, address and result registers.
module pba_dp #(
    parameter int MAX_BLOCKS = 64,
    parameter int CNT_W      = 7,
    parameter int IDX_W      = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pba_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                          kind,
    input  logic [pba_pkg::SIZE_W-1:0]    block_size,
    input  logic [pba_pkg::ADDR_W-1:0]    address,
    input  pba_pkg::dp_cmd_t              cmd,
    output pba_pkg::dp_stat_t             stat,
    output logic                          done,
    output logic [pba_pkg::STAT_W-1:0]    status,
    output logic [pba_pkg::ADDR_W-1:0]    granted_address,
    output logic                          page_is_cut,
    output logic [CNT_W-1:0]              free_count,
    output logic [CNT_W-1:0]              block_count,
    output logic [pba_pkg::SIZE_W-1:0]    current_block_size
);
    import pba_pkg::*;

    localparam int NGRP   = (MAX_BLOCKS + GRP_W - 1) / GRP_W;
    localparam int GRP_IW = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int FND_W  = GRP_IW + LANE_IW;
    localparam int PROD_W = SIZE_W + IDX_W;

    // configuration
    logic [ADDR_W-1:0] page_base_reg;
    logic [SIZE_W-1:0] page_size_reg;

    // latched request
    logic              kind_reg;
    logic [SIZE_W-1:0] bsize_reg;
    logic [ADDR_W-1:0] addr_reg;

    // page state
    logic [MAX_BLOCKS-1:0] busy_reg;
    logic                  cut_reg;
    logic [SIZE_W-1:0]     cut_size_reg;
    logic [CNT_W-1:0]      total_reg;
    logic [CNT_W-1:0]      free_reg;
    logic [SIZE_W-1:0]     span_reg;    // bytes covered by the blocks

    // scan and address
    logic [GRP_IW-1:0] grp_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [PROD_W-1:0] prod_reg;

    // results
    logic              done_reg;
    logic [STAT_W-1:0] status_reg;
    logic [ADDR_W-1:0] grant_reg;
    logic              out_cut_reg;
    logic [CNT_W-1:0]  out_free_reg;
    logic [CNT_W-1:0]  out_total_reg;
    logic [SIZE_W-1:0] out_size_reg;

    logic [ADDR_W-1:0] offset;
    logic [SIZE_W-1:0] div_dividend;
    logic [SIZE_W-1:0] div_divisor;
    logic              div_done;
    logic [SIZE_W-1:0] quo;
    logic [SIZE_W-1:0] rem;
    logic [IDX_W-1:0]  quo_idx;

    logic [GRP_W-1:0]   free_mat [NGRP];
    logic [GRP_W-1:0]   lane_vec;
    logic [LANE_IW-1:0] lane;
    logic [FND_W-1:0]   found_full;
    logic [IDX_W-1:0]   found_idx;
    logic               found;
    logic [CNT_W-1:0]   free_inc;

    assign offset       = addr_reg - page_base_reg;
    assign div_dividend = (kind_reg == KIND_FREE) ? offset[SIZE_W-1:0] : page_size_reg;
    assign div_divisor  = (kind_reg == KIND_FREE) ? cut_size_reg : bsize_reg;
    assign quo_idx      = quo[IDX_W-1:0];
    assign free_inc     = CNT_W'(free_reg + 1'b1);

    pba_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // free map in groups of GRP_W; lanes beyond the page count as taken
    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        for (genvar j = 0; j < GRP_W; j++)
        begin : g_lane
            localparam int B = g * GRP_W + j;
            if (B < MAX_BLOCKS)
            begin : g_real
                assign free_mat[g][j] = !busy_reg[B] && (CNT_W'(B) < total_reg);
            end
            else
            begin : g_pad
                assign free_mat[g][j] = 1'b0;
            end
        end
    end

    always_comb
    begin
        lane_vec = free_mat[grp_reg];
        lane     = '0;
        for (int j = GRP_W - 1; j >= 0; j--)
        begin
            if (lane_vec[j])
            begin
                lane = LANE_IW'(j);
            end
        end
        found      = |lane_vec;
        found_full = {grp_reg, lane};
        found_idx  = found_full[IDX_W-1:0];
    end

    always_comb
    begin
        stat.is_free    = (kind_reg == KIND_FREE);
        stat.bsize_zero = (bsize_reg == '0);
        stat.cut        = cut_reg;
        stat.size_match = (bsize_reg == cut_size_reg);
        stat.has_free   = (free_reg != '0);
        stat.in_range   = (offset < {{(ADDR_W-SIZE_W){1'b0}}, span_reg});
        stat.div_done   = div_done;
        stat.q_bad      = (quo == '0) || (quo > SIZE_W'(MAX_BLOCKS));
        stat.rem_zero   = (rem == '0);
        stat.idx_busy   = busy_reg[quo_idx];
        stat.found      = found;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_base_reg <= '0;
            page_size_reg <= SIZE_W'(4096);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PAGE_BASE: page_base_reg <= cfg_data;
                REG_PAGE_SIZE: page_size_reg <= cfg_data[SIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            bsize_reg <= block_size;
            addr_reg  <= address;
        end
        if (cmd.scan_step && found)
        begin
            idx_reg <= found_idx;
        end
        if (cmd.mul)
        begin
            prod_reg <= cut_size_reg * idx_reg;
        end
        if (cmd.finish)
        begin
            status_reg    <= cmd.code;
            grant_reg     <= (kind_reg == KIND_ALLOC && cmd.code == ST_DONE)
                             ? page_base_reg + ADDR_W'(prod_reg) : '0;
            out_cut_reg   <= cut_reg;
            out_free_reg  <= free_reg;
            out_total_reg <= total_reg;
            out_size_reg  <= cut_size_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= '0;
            cut_reg      <= 1'b0;
            cut_size_reg <= '0;
            total_reg    <= '0;
            free_reg     <= '0;
            span_reg     <= '0;
            grp_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.scan_init)
            begin
                grp_reg <= '0;
            end
            else if (cmd.scan_step && !found)
            begin
                grp_reg <= GRP_IW'(grp_reg + 1'b1);
            end

            if (cmd.do_cut)
            begin
                busy_reg     <= '0;
                cut_reg      <= 1'b1;
                cut_size_reg <= bsize_reg;
                total_reg    <= CNT_W'(quo);
                free_reg     <= CNT_W'(quo);
                span_reg     <= page_size_reg - rem;
            end
            else if (cmd.scan_step && found)
            begin
                busy_reg[found_idx] <= 1'b1;
                free_reg            <= CNT_W'(free_reg - 1'b1);
            end
            else if (cmd.do_release)
            begin
                if (free_inc == total_reg)
                begin
                    // last busy block gone: page goes back to free
                    busy_reg     <= '0;
                    cut_reg      <= 1'b0;
                    cut_size_reg <= '0;
                    total_reg    <= '0;
                    free_reg     <= '0;
                    span_reg     <= '0;
                end
                else
                begin
                    busy_reg[quo_idx] <= 1'b0;
                    free_reg          <= free_inc;
                end
            end
        end
    end

    assign done               = done_reg;
    assign status             = status_reg;
    assign granted_address    = grant_reg;
    assign page_is_cut        = out_cut_reg;
    assign free_count         = out_free_reg;
    assign block_count        = out_total_reg;
    assign current_block_size = out_size_reg;

endmodule

### hdl/pba_ctrl.sv
// Controller state machine sequencing check, divide, scan, address and result.
module pba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pba_pkg::dp_stat_t stat,
    output pba_pkg::dp_cmd_t  cmd
);
    import pba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SCAN,
        S_MUL,
        S_FINISH
    } state_t;

    state_t       state_reg;
    state_t       state_next;
    status_code_t code_reg;
    status_code_t code_next;
    logic         busy_reg;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    code_next  = ST_DONE;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.is_free)
                begin
                    priority if (stat.bsize_zero)
                    begin
                        code_next  = ST_BADSIZE;
                        state_next = S_FINISH;
                    end
                    else if (!stat.cut)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else if (stat.size_match && stat.has_free)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        code_next  = ST_NOFIT;
                        state_next = S_FINISH;
                    end
                end
                else if (stat.cut && stat.in_range)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    code_next  = ST_NOTFOUND;
                    state_next = S_FINISH;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    if (!stat.is_free)
                    begin
                        if (stat.q_bad)
                        begin
                            code_next  = ST_BADSIZE;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.do_cut    = 1'b1;
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    else if (stat.rem_zero && stat.idx_busy)
                    begin
                        cmd.do_release = 1'b1;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        code_next  = ST_NOTFOUND;
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.found)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_DONE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule
